FILE: src/cd_pkg.sv
// ----------------------------------------------------------------------------
// cd_pkg
// Shared types and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cd_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;

	typedef enum logic [1:0] {
		MODE_PUSH_HEAD = 2'd0,
		MODE_PUSH_TAIL = 2'd1,
		MODE_POP_HEAD  = 2'd2,
		MODE_POP_TAIL  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic    strobe;
		logic    pop_ok;
		status_t status;
	} res_info_t;

endpackage

FILE: src/cd_mem.sv
// ----------------------------------------------------------------------------
// cd_mem
// Single-port slot store with registered read data.
// ----------------------------------------------------------------------------
module cd_mem #(
	parameter int DEPTH = cd_pkg::DEPTH_DEFAULT,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [IDX_W-1:0]           addr,
	input  logic [cd_pkg::DATA_W-1:0]  wdata,
	output logic [cd_pkg::DATA_W-1:0]  rdata
);

	logic [cd_pkg::DATA_W-1:0] mem [DEPTH];
	logic [cd_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/cd_ctrl.sv
// ----------------------------------------------------------------------------
// cd_ctrl
// Head, tail and fill count bookkeeping; issues at most one slot access per request.
// ----------------------------------------------------------------------------
module cd_ctrl #(
	parameter int DEPTH = cd_pkg::DEPTH_DEFAULT,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 mode,
	output logic                       mem_we,
	output logic                       mem_re,
	output logic [IDX_W-1:0]           mem_addr,
	output cd_pkg::res_info_t          res,
	output logic [CNT_W-1:0]           count
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [IDX_W-1:0]  head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0]  count_q, count_d;
	cd_pkg::res_info_t res_s1, res_d;
	logic              empty, full;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_FULL);

	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		count_d       = count_q;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_addr      = '0;
		res_d.strobe  = accept;
		res_d.pop_ok  = 1'b0;
		res_d.status  = cd_pkg::ST_DONE;
		if (accept) begin
			case (cd_pkg::mode_t'(mode))
				cd_pkg::MODE_PUSH_HEAD, cd_pkg::MODE_PUSH_TAIL: begin
					if (full) begin
						res_d.status = cd_pkg::ST_OVERFLOW;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + 1'b1;
						if (empty) begin
							head_d   = '0;
							tail_d   = '0;
							mem_addr = '0;
						end else if (cd_pkg::mode_t'(mode) == cd_pkg::MODE_PUSH_HEAD) begin
							head_d   = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
							mem_addr = head_d;
						end else begin
							tail_d   = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
							mem_addr = tail_d;
						end
					end
				end
				cd_pkg::MODE_POP_HEAD, cd_pkg::MODE_POP_TAIL: begin
					if (empty) begin
						res_d.status = cd_pkg::ST_UNDERFLOW;
					end else begin
						mem_re       = 1'b1;
						res_d.pop_ok = 1'b1;
						count_d      = count_q - 1'b1;
						if (cd_pkg::mode_t'(mode) == cd_pkg::MODE_POP_HEAD) begin
							mem_addr = head_q;
							head_d   = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
						end else begin
							mem_addr = tail_q;
							tail_d   = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;
						end
						if (count_d == '0) begin
							head_d = '0;
							tail_d = '0;
						end
					end
				end
				default: begin
					res_d.status = cd_pkg::ST_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			res_s1  <= '0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			res_s1  <= res_d;
		end
	end

	assign res   = res_s1;
	assign count = count_q;

endmodule

FILE: src/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue held in a circular slot memory.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// mode selects push at the head, push at the tail, pop from the head or pop
// from the tail; value carries the element for a push.
// Every request gives exactly one result in the cycle after it is taken: done is
// high for one cycle, with popped, status and occupancy valid in that cycle.
// A new request may be issued in every cycle, so the sustained rate is one
// request per cycle; busy stays low.
// The latency is set by the single-port slot memory, whose read data is
// registered; a push is written at the edge that takes it, so a pop in the
// following cycle already sees it.
// A push into a full store reports overflow, a pop from an empty store
// reports underflow with popped at zero; neither changes the contents.
// Reset clears the indices and the fill count; the slots keep their contents.
// There is no result back-pressure: the receiver must take each result.
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int DEPTH = cd_pkg::DEPTH_DEFAULT,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        mode,
	input  logic signed [cd_pkg::DATA_W-1:0]  value,
	output logic                              done,
	output logic signed [cd_pkg::DATA_W-1:0]  popped,
	output logic [1:0]                        status,
	output logic [CNT_W-1:0]                  occupancy
);

	logic                       accept;
	logic                       mem_we, mem_re;
	logic [IDX_W-1:0]           mem_addr;
	logic [cd_pkg::DATA_W-1:0]  mem_rdata;
	cd_pkg::res_info_t          res;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	cd_ctrl #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (mode),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.res      (res),
		.count    (occupancy)
	);

	cd_mem #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (value),
		.rdata (mem_rdata)
	);

	assign done   = res.strobe;
	assign status = res.status;
	assign popped = res.pop_ok ? mem_rdata : '0;

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept && arst_n))
		else $error("result strobe does not match an earlier request");

	a_occupancy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= CNT_W'(DEPTH))
		else $error("occupancy exceeds the store depth");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == cd_pkg::ST_OVERFLOW |-> occupancy == CNT_W'(DEPTH))
		else $error("overflow reported while the store is not full");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == cd_pkg::ST_UNDERFLOW |-> occupancy == '0 && popped == '0)
		else $error("underflow reported with data or a nonempty store");

endmodule
